// ===== hw/rtl/tve_pkg.sv =====
package tve_pkg;

  // Field widths
  localparam int POS_W   = 16;
  localparam int DELTA_W = POS_W + 1;
  localparam int TIME_W  = 16;
  localparam int VEL_W   = 25;
  localparam int SPEED_W = 50;
  localparam int ALPHA_W = 16;

  // Serial datapath widths
  localparam int QUO_W   = 24;                 // |delta| * 256 fits 24 bits
  localparam int DIFF_W  = VEL_W + 1;          // target - velocity
  localparam int PROD_W  = DIFF_W + 1 + VEL_W; // multiplier accumulator + low shift register
  localparam int FRAC_W  = 16;                 // alpha is Q0.16
  localparam int STEP_W  = VEL_W + 2;          // correction term and velocity sum

  // Configuration port
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam logic CFG_IDX_TC = 1'b0;

  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 16'd52429;  // 0.8 in Q0.16
  localparam logic [TIME_W-1:0]  TC_RESET  = 16'd100;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic        [TIME_W-1:0]  time_t;
  typedef logic signed [VEL_W-1:0]   vel_t;
  typedef logic        [SPEED_W-1:0] speed_t;
  typedef logic        [ALPHA_W-1:0] alpha_t;

endpackage

// ===== hw/rtl/tve_if.sv =====
interface tve_in_if import tve_pkg::*; ();
  logic  valid;
  logic  ready;
  pos_t  primary_pos;
  pos_t  orthogonal_pos;
  time_t elapsed_ms;

  modport source (output valid, primary_pos, orthogonal_pos, elapsed_ms, input ready);
  modport sink   (input valid, primary_pos, orthogonal_pos, elapsed_ms, output ready);
endinterface

interface tve_out_if import tve_pkg::*; ();
  logic   valid;
  logic   ready;
  vel_t   y_velocity;
  vel_t   x_velocity;
  speed_t squared_speed;
  pos_t   touch_x;
  pos_t   touch_y;
  logic   velocity_updated;

  modport source (output valid, y_velocity, x_velocity, squared_speed, touch_x, touch_y,
                  velocity_updated, input ready);
  modport sink   (input valid, y_velocity, x_velocity, squared_speed, touch_x, touch_y,
                  velocity_updated, output ready);
endinterface

// ===== hw/rtl/tve_sdiv.sv =====
// Restoring divider, one quotient bit per cycle, numerator bits shifted in MSB first.
module tve_sdiv #(
  parameter int NW = 24,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [DW-1:0] rem_init,
  output logic          busy,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] sh_r, sh_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;
  logic [DW:0]   trial_sub;
  logic          fits;

  always_comb begin
    trial     = {rem_r, sh_r[NW-1]};
    trial_sub = trial - {1'b0, den_r};
    fits      = (trial >= {1'b0, den_r});
    rem_nxt   = fits ? trial_sub[DW-1:0] : trial[DW-1:0];
    sh_nxt    = {sh_r[NW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= num;
      rem_r <= rem_init;
      den_r <= den;
    end else if (busy_r) begin
      sh_r  <= sh_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = sh_r;

endmodule

// ===== hw/rtl/tve_smul.sv =====
// Shift-add multiplier: signed multiplicand, unsigned multiplier taken one bit a cycle, LSB first.
module tve_smul #(
  parameter int AW = 26,
  parameter int BW = 25
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic        [BW-1:0]    b,
  output logic                    busy,
  output logic signed [AW+BW:0]   prod
);

  localparam int CW = $clog2(BW + 1);

  logic signed [AW-1:0] a_r;
  logic        [BW-1:0] b_r;
  logic signed [AW:0]   acc_r;
  logic        [BW-1:0] lo_r;
  logic        [CW-1:0] cnt_r;
  logic                 busy_r;
  logic signed [AW:0]   addend;
  logic signed [AW:0]   sum;

  always_comb begin
    addend = b_r[0] ? {a_r[AW-1], a_r} : '0;
    sum    = acc_r + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(BW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
      lo_r  <= '0;
    end else if (busy_r) begin
      b_r   <= {1'b0, b_r[BW-1:1]};
      acc_r <= {sum[AW], sum[AW:1]};
      lo_r  <= {sum[0], lo_r[BW-1:1]};
    end
  end

  assign busy = busy_r;
  assign prod = {acc_r, lo_r};

endmodule

// ===== hw/rtl/touch_velocity_ewma_unit.sv =====
// Channel  Direction  Handshake        Payload
// in_ch    sink       valid/ready      primary_pos, orthogonal_pos, elapsed_ms
// out_ch   source     valid/ready      y_velocity, x_velocity, squared_speed,
//                                      touch_x, touch_y, velocity_updated
// cfg_*    APB slave  psel/penable     time_constant_ms at word 0, pready always high
//
// An updating event runs from acceptance to result through a load step, the 24-step
// serial divider, two 25-step passes through the serial multipliers (the alpha-weighted
// correction, then the squares), then hand-off, update and output load.
// An arming or zero-time event goes from acceptance straight to the output load. One
// event is worked on at a time; the next one is taken once the previous result sits in
// the output register.
// Reset is synchronous and active low; it restores the register to 100 ms and clears
// the filter state. A stalled result stays in the output register.
module touch_velocity_ewma_unit import tve_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tve_in_if.sink            in_ch,
  tve_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_UPD   = 8'b0001_0000,
    S_SQS   = 8'b0010_0000,
    S_SQ    = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration and filter state
  time_t  tc_r;
  logic   armed_r;
  pos_t   last_y_r, last_x_r;
  vel_t   vel_y_r, vel_x_r;
  speed_t speed_r;

  // Event working registers
  pos_t   pos_y_r, pos_x_r;
  time_t  elapsed_r;
  delta_t dy_r, dx_r;
  logic   alpha_sat_r;
  logic   upd_r;
  logic signed [STEP_W-1:0] step_y_r, step_x_r;

  // Output register
  logic   out_valid_r;
  vel_t   out_y_r, out_x_r;
  speed_t out_speed_r;
  pos_t   out_tx_r, out_ty_r;
  logic   out_upd_r;

  logic   in_fire;
  logic   out_load;
  logic   cfg_wr;
  delta_t dy_in, dx_in;
  delta_t abs_dy, abs_dx;

  logic               div_start;
  logic               div_a_busy, div_y_busy, div_x_busy;
  logic [ALPHA_W-1:0] quo_alpha;
  logic [QUO_W-1:0]   quo_y, quo_x;
  alpha_t             alpha;
  vel_t               tmag_y, tmag_x, target_y, target_x;
  logic signed [DIFF_W-1:0] diff_y, diff_x;
  vel_t               absv_y, absv_x;

  logic                     mul_start;
  logic                     mul_sq;
  logic                     mul_y_busy, mul_x_busy;
  logic signed [DIFF_W-1:0] mul_a_y, mul_a_x;
  logic        [VEL_W-1:0]  mul_b_y, mul_b_x;
  logic signed [PROD_W-1:0] prod_y, prod_x;
  logic signed [PROD_W-1:0] rnd_y, rnd_x;
  logic signed [STEP_W-1:0] vsum_y, vsum_x;
  speed_t                   speed_sum;

  function automatic vel_t sat_vel(input logic signed [STEP_W-1:0] v);
    vel_t r;
    if (v > STEP_W'(VEL_MAX)) begin
      r = VEL_MAX;
    end else if (v < STEP_W'(VEL_MIN)) begin
      r = VEL_MIN;
    end else begin
      r = v[VEL_W-1:0];
    end
    return r;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // Deltas against the stored positions, taken as the event is accepted
  assign dy_in  = {in_ch.primary_pos[POS_W-1], in_ch.primary_pos} - {last_y_r[POS_W-1], last_y_r};
  assign dx_in  = {in_ch.orthogonal_pos[POS_W-1], in_ch.orthogonal_pos}
                - {last_x_r[POS_W-1], last_x_r};
  assign abs_dy = dy_r[DELTA_W-1] ? -dy_r : dy_r;
  assign abs_dx = dx_r[DELTA_W-1] ? -dx_r : dx_r;

  // Dividers: alpha runs from a partial remainder of elapsed, valid only when elapsed < tau
  assign div_start = (state_r == S_START);

  tve_sdiv #(.NW(ALPHA_W), .DW(TIME_W)) u_div_alpha (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      ('0),
    .den      (tc_r),
    .rem_init (elapsed_r),
    .busy     (div_a_busy),
    .quo      (quo_alpha)
  );

  tve_sdiv #(.NW(QUO_W), .DW(TIME_W)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      ({abs_dy[POS_W-1:0], 8'h00}),
    .den      (elapsed_r),
    .rem_init ('0),
    .busy     (div_y_busy),
    .quo      (quo_y)
  );

  tve_sdiv #(.NW(QUO_W), .DW(TIME_W)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      ({abs_dx[POS_W-1:0], 8'h00}),
    .den      (elapsed_r),
    .rem_init ('0),
    .busy     (div_x_busy),
    .quo      (quo_x)
  );

  // Clamp alpha and form the signed error against the held velocity
  always_comb begin
    alpha    = (alpha_sat_r || (quo_alpha > ALPHA_MAX)) ? ALPHA_MAX : quo_alpha;
    tmag_y   = {1'b0, quo_y};
    tmag_x   = {1'b0, quo_x};
    target_y = dy_r[DELTA_W-1] ? -tmag_y : tmag_y;
    target_x = dx_r[DELTA_W-1] ? -tmag_x : tmag_x;
    diff_y   = {target_y[VEL_W-1], target_y} - {vel_y_r[VEL_W-1], vel_y_r};
    diff_x   = {target_x[VEL_W-1], target_x} - {vel_x_r[VEL_W-1], vel_x_r};
    absv_y   = vel_y_r[VEL_W-1] ? -vel_y_r : vel_y_r;
    absv_x   = vel_x_r[VEL_W-1] ? -vel_x_r : vel_x_r;
  end

  // Multipliers serve twice: alpha times error, then each velocity squared
  assign mul_sq    = (state_r == S_SQS);
  assign mul_start = mul_sq ||
                     ((state_r == S_DIV) && !div_a_busy && !div_y_busy && !div_x_busy);
  assign mul_a_y   = mul_sq ? {1'b0, absv_y} : diff_y;
  assign mul_a_x   = mul_sq ? {1'b0, absv_x} : diff_x;
  assign mul_b_y   = mul_sq ? absv_y : {{(VEL_W-ALPHA_W){1'b0}}, alpha};
  assign mul_b_x   = mul_sq ? absv_x : {{(VEL_W-ALPHA_W){1'b0}}, alpha};

  tve_smul #(.AW(DIFF_W), .BW(VEL_W)) u_mul_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a_y),
    .b     (mul_b_y),
    .busy  (mul_y_busy),
    .prod  (prod_y)
  );

  tve_smul #(.AW(DIFF_W), .BW(VEL_W)) u_mul_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a_x),
    .b     (mul_b_x),
    .busy  (mul_x_busy),
    .prod  (prod_x)
  );

  // Round half up, drop the Q0.16 fraction, then add to the velocity with headroom
  always_comb begin
    rnd_y     = prod_y + PROD_W'(32768);
    rnd_x     = prod_x + PROD_W'(32768);
    vsum_y    = {{(STEP_W-VEL_W){vel_y_r[VEL_W-1]}}, vel_y_r} + step_y_r;
    vsum_x    = {{(STEP_W-VEL_W){vel_x_r[VEL_W-1]}}, vel_x_r} + step_x_r;
    speed_sum = prod_y[SPEED_W-1:0] + prod_x[SPEED_W-1:0];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (!armed_r || (in_ch.elapsed_ms == '0)) ? S_OUT : S_START;
        end
      end
      S_START: state_nxt = S_DIV;
      S_DIV: begin
        if (mul_start) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (!mul_y_busy && !mul_x_busy) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: state_nxt = S_SQS;
      S_SQS: state_nxt = S_SQ;
      S_SQ: begin
        if (!mul_y_busy && !mul_x_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Filter state: arm on the first event, update on every timed event after that
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      last_y_r <= '0;
      last_x_r <= '0;
      vel_y_r  <= '0;
      vel_x_r  <= '0;
      speed_r  <= '0;
    end else begin
      if (in_fire) begin
        if (!armed_r) begin
          armed_r  <= 1'b1;
          last_y_r <= '0;
          last_x_r <= '0;
        end else if (in_ch.elapsed_ms != '0) begin
          last_y_r <= in_ch.primary_pos;
          last_x_r <= in_ch.orthogonal_pos;
        end
      end
      if (state_r == S_UPD) begin
        vel_y_r <= sat_vel(vsum_y);
        vel_x_r <= sat_vel(vsum_x);
      end
      if ((state_r == S_SQ) && !mul_y_busy && !mul_x_busy) begin
        speed_r <= speed_sum;
      end
    end
  end

  // Working registers of the event in hand
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pos_y_r   <= in_ch.primary_pos;
      pos_x_r   <= in_ch.orthogonal_pos;
      elapsed_r <= in_ch.elapsed_ms;
      dy_r      <= dy_in;
      dx_r      <= dx_in;
      upd_r     <= 1'b0;
    end
    if (state_r == S_START) begin
      alpha_sat_r <= (tc_r == '0) || (elapsed_r >= tc_r);
    end
    if ((state_r == S_MUL) && !mul_y_busy && !mul_x_busy) begin
      step_y_r <= rnd_y[FRAC_W+STEP_W-1:FRAC_W];
      step_x_r <= rnd_x[FRAC_W+STEP_W-1:FRAC_W];
    end
    if (state_r == S_UPD) begin
      upd_r <= 1'b1;
    end
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_y_r     <= vel_y_r;
      out_x_r     <= vel_x_r;
      out_speed_r <= speed_r;
      out_tx_r    <= pos_x_r;
      out_ty_r    <= pos_y_r;
      out_upd_r   <= upd_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.y_velocity       = out_y_r;
  assign out_ch.x_velocity       = out_x_r;
  assign out_ch.squared_speed    = out_speed_r;
  assign out_ch.touch_x          = out_tx_r;
  assign out_ch.touch_y          = out_ty_r;
  assign out_ch.velocity_updated = out_upd_r;

  // Configuration port: word index in paddr[2]
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_TC) ? {{(CFG_DW-TIME_W){1'b0}}, tc_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= TC_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == CFG_IDX_TC)) begin
      tc_r <= cfg_pwdata[TIME_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/tve_checker.sv =====
module tve_checker import tve_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input vel_t   y_velocity,
  input vel_t   x_velocity,
  input speed_t squared_speed,
  input logic   velocity_updated,
  input logic   cfg_pready
);

  logic [1:0] pend_r;
  logic       seen_r;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Count items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      seen_r <= 1'b0;
    end else begin
      pend_r <= pend_r + {1'b0, in_fire} - {1'b0, out_fire};
      if (out_fire) begin
        seen_r <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_no_third: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd2) |-> !in_fire)
    else $error("item taken with one in work and one waiting");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result offered with no item outstanding");

  a_first_arms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !seen_r |-> !velocity_updated && (y_velocity == '0) &&
                             (x_velocity == '0) && (squared_speed == '0))
    else $error("first result after reset is not an arming result");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port not ready");

endmodule

bind touch_velocity_ewma_unit tve_checker u_tve_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .y_velocity       (out_ch.y_velocity),
  .x_velocity       (out_ch.x_velocity),
  .squared_speed    (out_ch.squared_speed),
  .velocity_updated (out_ch.velocity_updated),
  .cfg_pready       (cfg_pready)
);
